FILE: rtl/static_target_kalman_3d_assert.svh
// Assertion macros for the static target Kalman filter.
// Uses the clk and arst_n names of the module that includes it.
`ifndef STATIC_TARGET_KALMAN_3D_ASSERT_SVH
`define STATIC_TARGET_KALMAN_3D_ASSERT_SVH

// same-cycle implication
`define STK_ASSERT_IMP(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("assertion failed");

// next-cycle implication
`define STK_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("assertion failed");

`endif

FILE: rtl/stk_pkg.sv
// Shared types and constants for the static target Kalman filter.
// No dependencies; imported by every module of the block.
`default_nettype none

package stk_pkg;

	localparam int VAR_FRAC_BITS = 24;
	localparam int POS_W = 32;
	localparam int VAR_W = 32;
	localparam int GAIN_W = VAR_FRAC_BITS + 1;     // gain k lies in [0, 1.0]
	localparam int CNT_W = $clog2(GAIN_W);
	localparam int SUM_W = VAR_W + 1;              // p + r
	localparam int MC_W = POS_W + 1;               // innovation z - x
	localparam int HI_W = MC_W + 1;                // upper product accumulator

	localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << VAR_FRAC_BITS;

	localparam logic [VAR_W-1:0] RST_PROCESS_NOISE = 32'd16777;
	localparam logic [VAR_W-1:0] RST_MEAS_NOISE = 32'd83886080;
	localparam logic [VAR_W-1:0] RST_INITIAL_VARIANCE = 32'd16777216;

	typedef logic signed [POS_W-1:0] pos_t;
	typedef logic [VAR_W-1:0] var_t;

	typedef enum logic [1:0] {
		ACT_INIT    = 2'd0,
		ACT_PREDICT = 2'd1,
		ACT_UPDATE  = 2'd2,
		ACT_RESET   = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		CFG_PROCESS_NOISE    = 2'd0,
		CFG_MEAS_NOISE       = 2'd1,
		CFG_INITIAL_VARIANCE = 2'd2
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_MUL,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_st_t;

endpackage

`default_nettype wire

FILE: rtl/static_target_kalman_3d.sv
// Top level of the static target Kalman filter: control, state, output register.
// Depends on stk_pkg, stk_div, stk_mul and static_target_kalman_3d_assert.svh.
//
// Usage:
//  Input channel (in_valid/in_ready) carries action and pos_x/y/z; one beat per
//  item. Output channel (out_valid/out_ready) returns one beat per item with the
//  estimate, shared variance and initialized flag after that item.
//  Config: cfg_we writes cfg_data to register cfg_index (0 process_noise,
//  1 meas_noise, 2 initial_variance); write only while the block is idle.
//  Flow: init, predict, reset and updates that change nothing go from accept to
//  the done state, which loads the output register. A real update first runs the
//  serial gain divider, then the four serial multipliers running side by side.
//  One item is in work at a time, so a new item is taken only once the last one is
//  through. in_ready is high only between items; the next item may be taken while
//  the previous result waits in the output register. If the receiver stalls, the
//  finished result waits in a holding state until the output register frees up.
//  Reset: config registers return to their defaults, estimate and variance clear,
//  the internal initialized flag is 0, no result is pending.
`default_nettype none

`include "static_target_kalman_3d_assert.svh"

module static_target_kalman_3d (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            cfg_we,
	input  wire [1:0]      cfg_index,
	input  stk_pkg::var_t  cfg_data,
	input  wire            in_valid,
	output logic           in_ready,
	input  wire [1:0]      action,
	input  stk_pkg::pos_t  pos_x,
	input  stk_pkg::pos_t  pos_y,
	input  stk_pkg::pos_t  pos_z,
	output logic           out_valid,
	input  wire            out_ready,
	output stk_pkg::pos_t  est_x,
	output stk_pkg::pos_t  est_y,
	output stk_pkg::pos_t  est_z,
	output stk_pkg::var_t  variance,
	output logic           initialized
);
	import stk_pkg::*;

	localparam int F = VAR_FRAC_BITS;
	localparam int DW = HI_W + 2;                  // delta plus estimate headroom
	localparam logic signed [DW-1:0] POS_MAX = DW'(64'sd2147483647);
	localparam logic signed [DW-1:0] POS_MIN = DW'(-64'sd2147483648);
	localparam logic [VAR_W-1:0] VAR_MAX = '1;

	state_t state_q, state_d;

	var_t process_noise_q, meas_noise_q, initial_variance_q;
	pos_t est_q [3];
	var_t var_q;
	logic valid_q;

	logic signed [MC_W-1:0] innov_q [3];
	pos_t pos_w [3];
	action_t act_w;

	logic accept, go_update, div_start, mul_start, out_load, out_free;
	logic [SUM_W-1:0] s_w;
	logic [VAR_W:0] pred_w;

	unit_st_t div_st;
	logic [GAIN_W-1:0] div_quo;
	unit_st_t mul_st [4];
	logic signed [HI_W-1:0] prod_hi [4];
	logic [GAIN_W-1:0] prod_lo [4];
	logic mul_done, mul_busy;

	pos_t est_new [3];
	var_t var_new;
	logic [HI_W:0] np_w;

	logic out_valid_q;
	pos_t out_est_q [3];
	var_t out_var_q;
	logic out_init_q;

	assign pos_w[0] = pos_x;
	assign pos_w[1] = pos_y;
	assign pos_w[2] = pos_z;
	assign act_w = action_t'(action);

	assign accept = in_valid && in_ready;
	assign s_w = {1'b0, var_q} + {1'b0, meas_noise_q};
	assign go_update = (act_w == ACT_UPDATE) && valid_q && (s_w != '0);
	assign pred_w = {1'b0, var_q} + {1'b0, process_noise_q};
	assign out_free = !out_valid_q || out_ready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			process_noise_q <= RST_PROCESS_NOISE;
			meas_noise_q <= RST_MEAS_NOISE;
			initial_variance_q <= RST_INITIAL_VARIANCE;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_PROCESS_NOISE:    process_noise_q <= cfg_data;
				CFG_MEAS_NOISE:       meas_noise_q <= cfg_data;
				CFG_INITIAL_VARIANCE: initial_variance_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// gain divider and the four serial multipliers
	stk_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.p      (var_q),
		.s      (s_w),
		.st     (div_st),
		.quo    (div_quo)
	);

	for (genvar i = 0; i < 3; i++) begin : g_axis
		stk_mul u_mul (
			.clk     (clk),
			.arst_n  (arst_n),
			.start   (mul_start),
			.mcand   (innov_q[i]),
			.mplier  (div_quo),
			.st      (mul_st[i]),
			.prod_hi (prod_hi[i]),
			.prod_lo (prod_lo[i])
		);
	end

	stk_mul u_mul_var (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.mcand   ({1'b0, var_q}),
		.mplier  (GAIN_ONE - div_quo),
		.st      (mul_st[3]),
		.prod_hi (prod_hi[3]),
		.prod_lo (prod_lo[3])
	);

	assign mul_done = mul_st[0].done & mul_st[1].done & mul_st[2].done & mul_st[3].done;
	assign mul_busy = mul_st[0].busy | mul_st[1].busy | mul_st[2].busy | mul_st[3].busy;

	// round to nearest: (prod + 2^(F-1)) >>> F is {hi, lo[F]} plus carry lo[F-1]
	always_comb begin
		logic signed [DW-1:0] delta;
		logic signed [DW-1:0] sum;
		for (int i = 0; i < 3; i++) begin
			delta = DW'($signed({prod_hi[i], prod_lo[i][F]}))
				+ DW'($signed({1'b0, prod_lo[i][F-1]}));
			sum = DW'(est_q[i]) + delta;
			if (sum > POS_MAX)
				est_new[i] = POS_MAX[POS_W-1:0];
			else if (sum < POS_MIN)
				est_new[i] = POS_MIN[POS_W-1:0];
			else
				est_new[i] = sum[POS_W-1:0];
		end
	end

	assign np_w = (HI_W+1)'({prod_hi[3][HI_W-2:0], prod_lo[3][F]})
		+ (HI_W+1)'(prod_lo[3][F-1]);
	assign var_new = (np_w > (HI_W+1)'(VAR_MAX)) ? VAR_MAX : np_w[VAR_W-1:0];

	// filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++)
				est_q[i] <= '0;
			var_q <= '0;
			valid_q <= 1'b0;
		end else if (accept) begin
			case (act_w)
				ACT_INIT: begin
					for (int i = 0; i < 3; i++)
						est_q[i] <= pos_w[i];
					var_q <= initial_variance_q;
					valid_q <= 1'b1;
				end
				ACT_PREDICT: begin
					if (valid_q)
						var_q <= pred_w[VAR_W] ? VAR_MAX : pred_w[VAR_W-1:0];
				end
				ACT_UPDATE: ;
				ACT_RESET: valid_q <= 1'b0;
				default: ;
			endcase
		end else if (state_q == ST_MUL && mul_done) begin
			for (int i = 0; i < 3; i++)
				est_q[i] <= est_new[i];
			var_q <= var_new;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < 3; i++)
				innov_q[i] <= MC_W'(pos_w[i]) - MC_W'(est_q[i]);
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid)
					state_d = go_update ? ST_DIV : ST_DONE;
			end
			ST_DIV: begin
				if (div_st.done)
					state_d = ST_MUL;
			end
			ST_MUL: begin
				if (mul_done)
					state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		div_start = 1'b0;
		mul_start = 1'b0;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				div_start = in_valid && go_update;
			end
			ST_DIV: mul_start = div_st.done;
			ST_MUL: ;
			ST_DONE: out_load = out_free;
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			for (int i = 0; i < 3; i++)
				out_est_q[i] <= est_q[i];
			out_var_q <= var_q;
			out_init_q <= valid_q;
		end
	end

	assign out_valid = out_valid_q;
	assign est_x = out_est_q[0];
	assign est_y = out_est_q[1];
	assign est_z = out_est_q[2];
	assign variance = out_var_q;
	assign initialized = out_init_q;

	`STK_ASSERT_IMP(a_div_only_in_div, div_st.busy || div_st.done, state_q == ST_DIV)
	`STK_ASSERT_IMP(a_mul_only_in_mul, mul_busy || mul_done, state_q == ST_MUL)
	`STK_ASSERT_IMP(a_gain_bound, div_st.done, div_quo <= GAIN_ONE)
	`STK_ASSERT_NEXT(a_result_loaded, state_q == ST_DONE && out_free, out_valid)

endmodule

`default_nettype wire

FILE: rtl/stk_div.sv
// Radix-2 restoring divider for the gain k = floor(p * 2^F / (p + r)).
// One quotient bit per cycle. Depends on stk_pkg.
`default_nettype none

module stk_div (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         start,
	input  stk_pkg::var_t               p,
	input  wire [stk_pkg::SUM_W-1:0]    s,
	output stk_pkg::unit_st_t           st,
	output logic [stk_pkg::GAIN_W-1:0]  quo
);
	import stk_pkg::*;

	logic [SUM_W-1:0]  rem_q;
	logic [SUM_W-1:0]  s_q;
	logic [GAIN_W-1:0] num_q;
	logic [GAIN_W-1:0] quo_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;

	logic [SUM_W:0]    rem_sh;
	logic [SUM_W:0]    diff;
	logic              ge;

	// remainder stays below s, so its shifted form stays below 2s
	assign rem_sh = {rem_q, num_q[GAIN_W-1]};
	assign diff = rem_sh - {1'b0, s_q};
	assign ge = (rem_sh >= {1'b0, s_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CNT_W'(GAIN_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// dividend p << F: high bits p >> 1 seed the remainder, then p[0], then zeros
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {2'b00, p[VAR_W-1:1]};
			num_q <= {p[0], {(GAIN_W-1){1'b0}}};
			s_q <= s;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[SUM_W-1:0] : rem_sh[SUM_W-1:0];
			num_q <= {num_q[GAIN_W-2:0], 1'b0};
			quo_q <= {quo_q[GAIN_W-2:0], ge};
		end
	end

	assign st.busy = busy_q;
	assign st.done = done_q;
	assign quo = quo_q;

endmodule

`default_nettype wire

FILE: rtl/stk_mul.sv
// Bit-serial shift-add multiplier: signed multiplicand times unsigned gain.
// One multiplier bit per cycle, LSB first. Depends on stk_pkg.
`default_nettype none

module stk_mul (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                start,
	input  wire signed [stk_pkg::MC_W-1:0]     mcand,
	input  wire [stk_pkg::GAIN_W-1:0]          mplier,
	output stk_pkg::unit_st_t                  st,
	output logic signed [stk_pkg::HI_W-1:0]    prod_hi,
	output logic [stk_pkg::GAIN_W-1:0]         prod_lo
);
	import stk_pkg::*;

	logic signed [MC_W-1:0] mcand_q;
	logic [GAIN_W-1:0]      mq_q;
	logic signed [HI_W-1:0] hi_q;
	logic [GAIN_W-1:0]      lo_q;
	logic [CNT_W-1:0]       cnt_q;
	logic                   busy_q;
	logic                   done_q;

	logic signed [HI_W:0]   addend;
	logic signed [HI_W:0]   sum_w;

	assign addend = mq_q[0] ? (HI_W+1)'(mcand_q) : '0;
	assign sum_w = (HI_W+1)'(hi_q) + addend;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CNT_W'(GAIN_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// low product bits fall out of the accumulator into lo_q one per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			mcand_q <= mcand;
			mq_q <= mplier;
			hi_q <= '0;
			lo_q <= '0;
		end else if (busy_q) begin
			mq_q <= {1'b0, mq_q[GAIN_W-1:1]};
			hi_q <= sum_w[HI_W:1];
			lo_q <= {sum_w[0], lo_q[GAIN_W-1:1]};
		end
	end

	assign st.busy = busy_q;
	assign st.done = done_q;
	assign prod_hi = hi_q;
	assign prod_lo = lo_q;

endmodule

`default_nettype wire
